### rtl/trks_pkg.sv
package trks_pkg;

    localparam int MID_W      = 24;
    localparam int SPREAD_IN_W = 24;
    localparam int SPREAD_W   = 25;
    localparam int PNL_W      = 48;
    localparam int VOL_W      = 24;
    localparam int MULT_W     = 8;
    localparam int SUM_W      = 32;
    localparam int LANES      = 3;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 56;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    localparam int DEF_VOL_WINDOW_LEN = 200;
    localparam int DEF_BASELINE_LEN   = 200;

    localparam logic [1:0] REG_PNL_LEVEL   = 2'd0;
    localparam logic [1:0] REG_VOL_LEVEL   = 2'd1;
    localparam logic [1:0] REG_SPREAD_MULT = 2'd2;
    localparam logic [1:0] REG_DOUBLE_MODE = 2'd3;

    localparam logic signed [PNL_W-1:0] RST_PNL_LEVEL   = -48'sd256000;
    localparam logic [VOL_W-1:0]        RST_VOL_LEVEL   = 24'd12800;
    localparam logic [MULT_W-1:0]       RST_SPREAD_MULT = 8'd10;

    typedef struct packed {
        logic sq;
        logic acc;
        logic mul;
        logic mul2;
        logic cmp;
    } t_ctrl;

endpackage

### rtl/trks_ram.sv
module trks_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 200
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/trks_spread_lane.sv
module trks_spread_lane #(
    parameter int BASELINE_LEN = trks_pkg::DEF_BASELINE_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  trks_pkg::t_ctrl               i_ctrl,
    input  logic [trks_pkg::SPREAD_W-1:0] i_spread,
    input  logic [trks_pkg::MULT_W-1:0]   i_multiple,
    output logic                          o_trip
);

    localparam int BW = $clog2(BASELINE_LEN + 1);
    localparam int LW = trks_pkg::SPREAD_W + BW;
    localparam int RW = trks_pkg::SUM_W + trks_pkg::MULT_W;
    localparam int XW = (LW > RW) ? LW : RW;

    logic [trks_pkg::SUM_W-1:0] r_sum, n_sum;
    logic [BW-1:0]              r_fill;
    logic [LW-1:0]              r_lhs;
    logic [RW-1:0]              r_rhs;
    logic                       r_armed;
    logic [trks_pkg::SUM_W:0]   w_add;

    assign w_add = {1'b0, r_sum} + (trks_pkg::SUM_W + 1)'(i_spread);
    assign n_sum = w_add[trks_pkg::SUM_W] ? {trks_pkg::SUM_W{1'b1}}
                                          : w_add[trks_pkg::SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
        end else if (i_ctrl.acc && (r_fill < BW'(BASELINE_LEN))) begin
            r_sum  <= n_sum;
            r_fill <= r_fill + BW'(1);
        end
    end

    // products of the locked baseline test
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_lhs   <= LW'(i_spread) * LW'(r_fill);
            r_rhs   <= RW'(r_sum) * RW'(i_multiple);
            r_armed <= (r_fill >= BW'(BASELINE_LEN)) && (r_sum != '0);
        end
    end

    assign o_trip = r_armed && (XW'(r_lhs) > XW'(r_rhs));

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= BW'(BASELINE_LEN))
        else $error("baseline count beyond its length");
`endif

endmodule

### rtl/trks_vol_window.sv
module trks_vol_window #(
    parameter int VOL_WINDOW_LEN = trks_pkg::DEF_VOL_WINDOW_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  trks_pkg::t_ctrl            i_ctrl,
    input  logic [trks_pkg::MID_W-1:0] i_mid,
    input  logic [trks_pkg::VOL_W-1:0] i_vol_level,
    output logic                       o_trip
);

    localparam int CW    = $clog2(VOL_WINDOW_LEN + 1);
    localparam int HW    = $clog2(VOL_WINDOW_LEN);
    localparam int SUMW  = trks_pkg::MID_W + CW;
    localparam int SQW   = 2 * trks_pkg::MID_W + CW;
    localparam int PRODW = 2 * SUMW;
    localparam int MSQW  = 2 * trks_pkg::MID_W;
    localparam int V2W   = 2 * trks_pkg::VOL_W;

    logic [HW-1:0]              r_head;
    logic [CW-1:0]              r_fill;
    logic [SUMW-1:0]            r_total;
    logic [SQW-1:0]             r_sq;
    logic [trks_pkg::MID_W-1:0] r_old, w_rdata;
    logic [MSQW-1:0]            r_old_sq, r_mid_sq;
    logic [PRODW-1:0]           r_nq, r_ss, r_num, r_lim;
    logic [V2W-1:0]             r_v2;
    logic [2*CW-1:0]            r_nn1;
    logic                       r_two;
    logic                       w_full;

    assign w_full = (r_fill >= CW'(VOL_WINDOW_LEN));

    trks_ram #(
        .WIDTH (trks_pkg::MID_W),
        .DEPTH (VOL_WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.acc),
        .i_waddr (r_head),
        .i_wdata (i_mid),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    // oldest mid leaves only once the window is full
    always_ff @(posedge i_clk) begin
        if (i_ctrl.sq) begin
            r_old    <= w_full ? w_rdata : '0;
            r_old_sq <= w_full ? MSQW'(w_rdata) * MSQW'(w_rdata) : '0;
            r_mid_sq <= MSQW'(i_mid) * MSQW'(i_mid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_fill  <= '0;
            r_total <= '0;
            r_sq    <= '0;
        end else if (i_ctrl.acc) begin
            r_total <= r_total - SUMW'(r_old) + SUMW'(i_mid);
            r_sq    <= r_sq - SQW'(r_old_sq) + SQW'(r_mid_sq);
            if (!w_full) begin
                r_fill <= r_fill + CW'(1);
            end
            if (r_head == HW'(VOL_WINDOW_LEN - 1)) begin
                r_head <= '0;
            end else begin
                r_head <= r_head + HW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_nq  <= PRODW'(r_fill) * PRODW'(r_sq);
            r_ss  <= PRODW'(r_total) * PRODW'(r_total);
            r_v2  <= V2W'(i_vol_level) * V2W'(i_vol_level);
            r_nn1 <= (2 * CW)'(r_fill) * (2 * CW)'(r_fill - CW'(1));
            r_two <= (r_fill >= CW'(2));
        end
        if (i_ctrl.mul2) begin
            r_num <= r_nq - r_ss;
            r_lim <= PRODW'(r_v2) * PRODW'(r_nn1);
        end
    end

    assign o_trip = r_two && (r_num > r_lim);

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(VOL_WINDOW_LEN))
        else $error("window count beyond its length");
`endif
`ifndef SYNTH
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.acc && !w_full |=> r_fill == $past(r_fill) + CW'(1))
        else $error("window count did not advance");
`endif

endmodule

### rtl/trks_merge.sv
module trks_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  trks_pkg::t_ctrl                     i_ctrl,
    input  logic signed [trks_pkg::PNL_W-1:0]   i_pnl,
    input  logic signed [trks_pkg::PNL_W-1:0]   i_pnl_level,
    input  logic                                i_vol_trip,
    input  logic [trks_pkg::LANES-1:0]          i_spread_trip,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [trks_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_kill,
    output logic                                o_free
);

    logic                               r_kill;
    logic signed [trks_pkg::PNL_W-1:0]  r_min;
    logic                               r_valid;
    logic [trks_pkg::OUT_DATA_W-1:0]    r_data;
    logic                               w_pnl_trip;
    logic                               w_kill;
    logic signed [trks_pkg::PNL_W-1:0]  w_min;

    assign w_pnl_trip = i_pnl < i_pnl_level;
    assign w_min      = (i_pnl < r_min) ? i_pnl : r_min;
    assign w_kill     = w_pnl_trip || i_vol_trip || (i_spread_trip != '0);
    assign o_free     = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kill  <= 1'b0;
            r_min   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_ctrl.cmp) begin
                r_valid <= 1'b1;
                if (!r_kill) begin
                    r_kill <= w_kill;
                    r_min  <= w_min;
                end
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp) begin
            if (r_kill) begin
                r_data <= {2'b00, r_min, 3'b000, 1'b0, 1'b0, 1'b1};
            end else begin
                r_data <= {2'b00, w_min, i_spread_trip, i_vol_trip, w_pnl_trip, w_kill};
            end
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_kill     = r_kill;

`ifndef SYNTH
    a_kill_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kill |=> r_kill)
        else $error("kill latch released");
`endif
`ifndef SYNTH
    a_trip_kills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_data[5:1] != '0) |-> r_data[0] && r_kill)
        else $error("trip reported without kill");
`endif

endmodule

### rtl/trading_risk_kill_switch_unit.sv
// risk kill switch for a market tick stream
// s_axis carries one tick per transfer, tdata from bit 0 up: proxy_mid[23:0],
// spread_a[47:24], spread_b[71:48], spread_c[95:72], total_pnl[143:96]
// m_axis returns one result per tick, tdata from bit 0 up: kill_active,
// pnl_tripped, vol_tripped, spread_tripped[5:3], lowest_pnl[53:6], zero pad
// apb registers at byte 0x00 pnl level, 0x08 vol level, 0x10 spread
// multiple, 0x18 double spread mode; write only while no tick is in flight
// a tick runs through square, accumulate, two product cycles and the
// compare, one at a time: result valid 5 cycles after the tick transfer, and
// a new tick every 6 cycles; the product cycles of the window variance set
// this figure, the three spread lanes run alongside
// the result sits in an output register, so the next tick is taken while it
// waits; a stalled receiver holds the compare step until the register frees
// reset clears window, baselines, lowest profit and kill latch and loads the
// register defaults; window entries are not cleared, only read once written
// after the kill latches, ticks are taken and answered without state change
module trading_risk_kill_switch_unit #(
    parameter int VOL_WINDOW_LEN = trks_pkg::DEF_VOL_WINDOW_LEN,
    parameter int BASELINE_LEN   = trks_pkg::DEF_BASELINE_LEN
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // proxy_mid, spread_a, spread_b, spread_c, total_pnl
    input  logic [trks_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // kill_active, pnl_tripped, vol_tripped, spread_tripped, lowest_pnl, pad
    output logic [trks_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [trks_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [trks_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [trks_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_CMP  = 3'd5;

    logic [2:0] r_state, n_state;

    logic signed [trks_pkg::PNL_W-1:0] r_pnl_level;
    logic [trks_pkg::VOL_W-1:0]        r_vol_level;
    logic [trks_pkg::MULT_W-1:0]       r_mult;
    logic                              r_double;

    logic [trks_pkg::MID_W-1:0]        r_mid;
    logic [trks_pkg::SPREAD_W-1:0]     r_sp [trks_pkg::LANES];
    logic signed [trks_pkg::PNL_W-1:0] r_pnl;

    trks_pkg::t_ctrl                   w_ctrl;
    logic                              w_accept;
    logic                              w_kill;
    logic                              w_free;
    logic                              w_vol_trip;
    logic [trks_pkg::LANES-1:0]        w_spread_trip;
    logic [1:0]                        w_reg;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // configuration registers
    assign pready = 1'b1;
    assign w_reg  = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pnl_level <= trks_pkg::RST_PNL_LEVEL;
            r_vol_level <= trks_pkg::RST_VOL_LEVEL;
            r_mult      <= trks_pkg::RST_SPREAD_MULT;
            r_double    <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg)
                trks_pkg::REG_PNL_LEVEL:   r_pnl_level <= pwdata[trks_pkg::PNL_W-1:0];
                trks_pkg::REG_VOL_LEVEL:   r_vol_level <= pwdata[trks_pkg::VOL_W-1:0];
                trks_pkg::REG_SPREAD_MULT: r_mult      <= pwdata[trks_pkg::MULT_W-1:0];
                trks_pkg::REG_DOUBLE_MODE: r_double    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            trks_pkg::REG_PNL_LEVEL:   prdata = trks_pkg::APB_DATA_W'(unsigned'(r_pnl_level));
            trks_pkg::REG_VOL_LEVEL:   prdata = trks_pkg::APB_DATA_W'(r_vol_level);
            trks_pkg::REG_SPREAD_MULT: prdata = trks_pkg::APB_DATA_W'(r_mult);
            trks_pkg::REG_DOUBLE_MODE: prdata = trks_pkg::APB_DATA_W'(r_double);
            default:                   prdata = '0;
        endcase
    end

    // tick capture, spreads doubled here in stress mode
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mid <= s_axis_tdata[23:0];
            r_sp[0] <= r_double ? {s_axis_tdata[47:24], 1'b0} : {1'b0, s_axis_tdata[47:24]};
            r_sp[1] <= r_double ? {s_axis_tdata[71:48], 1'b0} : {1'b0, s_axis_tdata[71:48]};
            r_sp[2] <= r_double ? {s_axis_tdata[95:72], 1'b0} : {1'b0, s_axis_tdata[95:72]};
            r_pnl <= s_axis_tdata[143:96];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_SQ;
            ST_SQ:   n_state = ST_ACC;
            ST_ACC:  n_state = ST_MUL;
            ST_MUL:  n_state = ST_MUL2;
            ST_MUL2: n_state = ST_CMP;
            ST_CMP:  if (w_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        w_ctrl.sq   = (r_state == ST_SQ);
        w_ctrl.acc  = (r_state == ST_ACC) && !w_kill;
        w_ctrl.mul  = (r_state == ST_MUL);
        w_ctrl.mul2 = (r_state == ST_MUL2);
        w_ctrl.cmp  = (r_state == ST_CMP) && w_free;
    end

    trks_vol_window #(
        .VOL_WINDOW_LEN (VOL_WINDOW_LEN)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_mid       (r_mid),
        .i_vol_level (r_vol_level),
        .o_trip      (w_vol_trip)
    );

    for (genvar g = 0; g < trks_pkg::LANES; g++) begin : g_lane
        trks_spread_lane #(
            .BASELINE_LEN (BASELINE_LEN)
        ) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_spread   (r_sp[g]),
            .i_multiple (r_mult),
            .o_trip     (w_spread_trip[g])
        );
    end

    trks_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_pnl         (r_pnl),
        .i_pnl_level   (r_pnl_level),
        .i_vol_trip    (w_vol_trip),
        .i_spread_trip (w_spread_trip),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata),
        .o_kill        (w_kill),
        .o_free        (w_free)
    );

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_SQ) && !s_axis_tready)
        else $error("tick taken while another is in flight");
`endif

endmodule
